// ===== rtl/core/mlp_pkg.sv =====
package mlp_pkg;

  // line parsing phase
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  // known keys, K_NONE for an unknown or not yet decided key
  typedef enum logic [2:0] {
    K_FORMAT = 3'd0,
    K_ID     = 3'd1,
    K_NAME   = 3'd2,
    K_EXEC   = 3'd3,
    K_FLAGS  = 3'd4,
    K_NONE   = 3'd7
  } key_t;

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_END     = 2'd1,
    EV_VERDICT = 2'd2
  } ev_kind_t;

  localparam int NUM_KEYS   = 5;
  localparam int MAX_EVENTS = 3;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  localparam logic [31:0] FORMAT_ONE = 32'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [1:0]  field_code;
    logic [6:0]  char_position;
    logic [7:0]  char_value;
    logic        manifest_ok;
    logic [31:0] flags_value;
    logic        format_version;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  cand;
    logic [2:0]  kpos;
    key_t        akey;
    logic [7:0]  vlen;
    logic [31:0] acc;
    logic [31:0] flags;
    logic [3:0]  seen;
    logic        err;
  } parser_state_t;

  typedef struct packed {
    logic [1:0]                count;
    out_item_t [MAX_EVENTS-1:0] item;
  } step_out_t;

  localparam parser_state_t PARSER_RESET = '{
    phase: PH_START,
    cand:  5'h1F,
    kpos:  3'd0,
    akey:  K_NONE,
    vlen:  8'd0,
    acc:   32'd0,
    flags: 32'd0,
    seen:  4'd0,
    err:   1'b0
  };

  // key text, left-aligned, zero padded to eight characters
  function automatic logic [7:0] key_char(input key_t k, input logic [2:0] p);
    logic [7:0][7:0] t;
    case (k)
      K_FORMAT: t = {"format", 16'h0};
      K_ID:     t = {"id", 48'h0};
      K_NAME:   t = {"name", 32'h0};
      K_EXEC:   t = {"exec", 32'h0};
      K_FLAGS:  t = {"flags", 24'h0};
      default:  t = '0;
    endcase
    return t[3'd7 - p];
  endfunction

  function automatic logic [2:0] key_len(input key_t k);
    logic [2:0] n;
    case (k)
      K_FORMAT: n = 3'd6;
      K_ID:     n = 3'd2;
      K_NAME:   n = 3'd4;
      K_EXEC:   n = 3'd4;
      K_FLAGS:  n = 3'd5;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // string keys map to field codes id 0, name 1, exec 2
  function automatic logic [1:0] field_of(input key_t k);
    return k[1:0] - 2'd1;
  endfunction

endpackage

// ===== rtl/core/mlp_in_if.sv =====
interface mlp_in_if;
  import mlp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mlp_out_if.sv =====
interface mlp_out_if;
  import mlp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mlp_step.sv =====
module mlp_step #(
  parameter int ID_CAPACITY   = 32,
  parameter int NAME_CAPACITY = 64,
  parameter int EXEC_CAPACITY = 128
) (
  input  mlp_pkg::parser_state_t state,
  input  mlp_pkg::in_item_t      item,
  output mlp_pkg::parser_state_t state_next,
  output mlp_pkg::step_out_t     result
);
  import mlp_pkg::*;

  localparam logic [8:0] ID_CAP   = 9'(ID_CAPACITY);
  localparam logic [8:0] NAME_CAP = 9'(NAME_CAPACITY);
  localparam logic [8:0] EXEC_CAP = 9'(EXEC_CAPACITY);

  logic [7:0]    b;
  logic          is_eol;
  logic          is_digit;
  logic          is_print;
  logic          num_ovf;
  logic          cap_full;
  logic          close;
  logic [35:0]   num_wide;
  logic [8:0]    cap;
  logic [7:0]    vlen_sat;
  logic [4:0]    cand_after;
  logic [2:0]    kpos_inc;
  key_t          match_key;
  parser_state_t work;
  logic          emit_byte;
  logic          emit_end;
  out_item_t     ev_byte;
  out_item_t     ev_end;

  assign b        = item.data_byte;
  assign is_eol   = (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_print = (b >= CH_PRINT_LO) && (b <= CH_PRINT_HI);
  // acc * 10 + digit, overflow when it leaves 32 bits
  assign num_wide = ({4'b0, state.acc} << 3) + ({4'b0, state.acc} << 1) + 36'(b[3:0]);
  assign num_ovf  = |num_wide[35:32];
  assign cap_full = ({1'b0, state.vlen} + 9'd1) >= cap;
  assign vlen_sat = (state.vlen == 8'hFF) ? state.vlen : state.vlen + 8'd1;
  assign kpos_inc = (state.kpos == 3'd7) ? state.kpos : state.kpos + 3'd1;
  assign close    = (is_eol && !state.err) || item.last_byte;

  always_comb begin
    case (state.akey)
      K_ID:    cap = ID_CAP;
      K_NAME:  cap = NAME_CAP;
      default: cap = EXEC_CAP;
    endcase
  end

  // candidate narrowing on a key byte, and the decision on '='
  always_comb begin : key_match
    cand_after = state.cand;
    match_key  = K_NONE;
    for (int c = 0; c < NUM_KEYS; c++) begin
      if (state.cand[c] && (state.kpos >= key_len(key_t'(3'(c))) ||
                            key_char(key_t'(3'(c)), state.kpos) != b)) begin
        cand_after[c] = 1'b0;
      end
      if (state.cand[c] && key_len(key_t'(3'(c))) == state.kpos) begin
        match_key = key_t'(3'(c));
      end
    end
  end

  always_comb begin : parse
    work      = state;
    emit_byte = 1'b0;
    emit_end  = 1'b0;
    ev_byte   = '0;
    ev_end    = '0;
    if (!state.err && !is_eol) begin
      case (state.phase)
        PH_START: begin
          if (b == CH_HASH) begin
            work.phase = PH_SKIP;
          end else if (b == CH_EQ) begin
            work.err = 1'b1;
          end else begin
            work.phase = PH_KEY;
            work.cand  = cand_after;
            work.kpos  = kpos_inc;
          end
        end
        PH_KEY: begin
          if (b == CH_EQ) begin
            work.akey  = match_key;
            work.phase = (match_key == K_NONE) ? PH_SKIP : PH_VALUE;
          end else begin
            work.cand = cand_after;
            work.kpos = kpos_inc;
          end
        end
        PH_VALUE: begin
          if (state.akey == K_FORMAT || state.akey == K_FLAGS) begin
            if (!is_digit || num_ovf) begin
              work.err = 1'b1;
            end else begin
              work.acc  = num_wide[31:0];
              work.vlen = vlen_sat;
            end
          end else if (!is_print || cap_full ||
                       (state.akey == K_EXEC && state.vlen == 8'd0 && b != CH_SLASH)) begin
            work.err = 1'b1;
          end else begin
            emit_byte             = 1'b1;
            ev_byte.event_kind    = EV_BYTE;
            ev_byte.field_code    = field_of(state.akey);
            ev_byte.char_position = state.vlen[6:0];
            ev_byte.char_value    = b;
            work.vlen             = state.vlen + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
    // line close, on a line end or after the final byte
    if (close) begin
      if (!work.err) begin
        case (work.phase)
          PH_KEY: begin
            work.err = 1'b1;
          end
          PH_VALUE: begin
            if (work.vlen == 8'd0) begin
              work.err = 1'b1;
            end else if (work.akey == K_FORMAT) begin
              if (work.acc != FORMAT_ONE) work.err = 1'b1;
              else work.seen[0] = 1'b1;
            end else if (work.akey == K_FLAGS) begin
              work.flags = work.acc;
            end else begin
              emit_end                     = 1'b1;
              ev_end.event_kind            = EV_END;
              ev_end.field_code            = field_of(work.akey);
              ev_end.char_position         = work.vlen[6:0];
              work.seen[work.akey[1:0]]    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      work.phase = PH_START;
      work.cand  = 5'h1F;
      work.kpos  = 3'd0;
      work.akey  = K_NONE;
      work.vlen  = 8'd0;
      work.acc   = 32'd0;
    end
  end

  always_comb begin : emit
    out_item_t  verdict;
    logic [1:0] n;
    verdict                = '0;
    verdict.event_kind     = EV_VERDICT;
    verdict.manifest_ok    = !work.err && (&work.seen);
    verdict.format_version = !work.err && work.seen[0];
    verdict.flags_value    = work.err ? 32'd0 : work.flags;
    result = '0;
    n      = 2'd0;
    if (emit_byte) begin
      result.item[n] = ev_byte;
      n = n + 2'd1;
    end
    if (emit_end) begin
      result.item[n] = ev_end;
      n = n + 2'd1;
    end
    if (item.last_byte) begin
      result.item[n] = verdict;
      n = n + 2'd1;
    end
    if (n != 2'd0) result.item[n - 2'd1].last_of_run = 1'b1;
    result.count = n;
    state_next   = item.last_byte ? PARSER_RESET : work;
  end

endmodule

// ===== rtl/core/manifest_line_parser_core.sv =====
// Manifest line parser: takes manifest text one byte a beat on text and
// gives event beats on events (string field bytes, string field ends with
// their length, and a verdict after the byte marked last). A byte is taken
// at the edge where it is offered with text ready high; its events enter
// the result queue at that edge. A byte raises zero to three event beats,
// which leave one a cycle while the consumer is ready, through a four-entry
// result queue. Text is held off while fewer than three queue entries are
// free. Every byte that is not marked last raises at most one event, so
// while the consumer takes a beat every cycle the parser takes a byte every
// cycle. A final byte that raises two or three beats (a string end and the
// verdict, plus a string byte when it lands in a string value) holds text
// off after it until at most one queue entry is in use. After an error no
// events come until the verdict, which then reports failure. No start-up
// pass: text ready is high from the first cycle after reset.
module manifest_line_parser_core #(
  parameter int ID_CAPACITY   = 32,
  parameter int NAME_CAPACITY = 64,
  parameter int EXEC_CAPACITY = 128
) (
  input logic       clk,
  input logic       rst,
  mlp_in_if.sink    text,
  mlp_out_if.source events
);
  import mlp_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  parser_state_t    state;
  parser_state_t    state_next;
  step_out_t        step;
  out_item_t        queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             take;
  logic             give;
  logic [PTR_W:0]   push_n;

  // room for the worst case of one byte's events, nothing taken in reset
  assign text.ready = !rst && (fill <= (PTR_W+1)'(QUEUE_DEPTH - MAX_EVENTS));
  assign take       = text.valid && text.ready;
  assign give       = events.valid && events.ready;
  assign push_n     = take ? (PTR_W+1)'(step.count) : '0;

  // one pass of the line parser per text beat
  mlp_step #(
    .ID_CAPACITY  (ID_CAPACITY),
    .NAME_CAPACITY(NAME_CAPACITY),
    .EXEC_CAPACITY(EXEC_CAPACITY)
  ) u_step (
    .state     (state),
    .item      (text.data),
    .state_next(state_next),
    .result    (step)
  );

  // parser state only moves on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSER_RESET;
    end else if (take) begin
      state <= state_next;
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PTR_W-1:0];
      if (give) rd_ptr <= rd_ptr + PTR_W'(1);
      fill <= fill + push_n - (PTR_W+1)'(give);
    end
  end

  // event payload, written in order from the write pointer
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
        if (2'(i) < step.count) queue[wr_ptr + PTR_W'(i)] <= step.item[i];
      end
    end
  end

  assign events.valid = fill != '0;
  assign events.data  = queue[rd_ptr];

endmodule

// ===== rtl/core/mlp_checker.sv =====
module mlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [1:0]  field_code,
  input logic [6:0]  char_position,
  input logic [7:0]  char_value,
  input logic        manifest_ok,
  input logic [31:0] flags_value,
  input logic        format_version,
  input logic        last_of_run
);
  import mlp_pkg::*;

  // stalled event beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({event_kind, field_code, char_position, char_value,
               manifest_ok, flags_value, format_version, last_of_run}))
    else $error("event beat changed while stalled");

  // the verdict always closes the run of its byte
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_VERDICT |-> last_of_run)
    else $error("verdict without last_of_run");

  // verdict fields stay clear on string events
  a_string_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_VERDICT |->
      !manifest_ok && flags_value == 32'd0 && !format_version && field_code != 2'd3)
    else $error("string event carries verdict fields");

  // string bytes are printable
  a_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_BYTE |->
      char_value >= CH_PRINT_LO && char_value <= CH_PRINT_HI)
    else $error("non-printable string byte");

endmodule

bind manifest_line_parser_core mlp_checker u_mlp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (events.valid),
  .out_ready     (events.ready),
  .event_kind    (events.data.event_kind),
  .field_code    (events.data.field_code),
  .char_position (events.data.char_position),
  .char_value    (events.data.char_value),
  .manifest_ok   (events.data.manifest_ok),
  .flags_value   (events.data.flags_value),
  .format_version(events.data.format_version),
  .last_of_run   (events.data.last_of_run)
);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int ID_CAP       = 32;
  localparam int NAME_CAP     = 64;
  localparam int EXEC_CAP     = 128;
  localparam int RANDOM_BYTES = 400;
  // last stretch of text bytes sent with no idling on either side
  localparam int QUIET_TAIL   = 120;
  // settling time after the final event beat
  localparam int DRAIN_CYCLES = 8;
  // the longest correct pause without any beat is a sender gap plus a
  // receiver stall plus the queue latency
  localparam int STALL_LIMIT  = 2000;

  typedef enum logic [1:0] {
    FLD_ID   = 2'd0,
    FLD_NAME = 2'd1,
    FLD_EXEC = 2'd2
  } field_t;

  typedef enum int {
    LN_FORMAT, LN_ID, LN_NAME, LN_EXEC, LN_FLAGS,
    LN_COMMENT, LN_BLANK, LN_OTHER, LN_FAULT
  } line_t;

  // parser mirror: works out the event beats of each text byte and checks
  // the beats that come back in order
  class manifest_scoreboard;
    out_item_t   expected_events[$];
    out_item_t   step_events[$];
    int          failures;
    int          string_events;
    int          verdicts;
    int          good_verdicts;
    phase_t      phase;
    logic [4:0]  cand;
    logic [2:0]  kpos;
    key_t        akey;
    logic [7:0]  vlen;
    logic [31:0] acc;
    logic [31:0] flags_word;
    logic [3:0]  seen;
    logic        err;

    function new();
      failures      = 0;
      string_events = 0;
      verdicts      = 0;
      good_verdicts = 0;
      restart();
    endfunction

    function void open_line();
      phase = PH_START;
      cand  = 5'h1F;
      kpos  = 3'd0;
      akey  = K_NONE;
      vlen  = 8'd0;
      acc   = 32'd0;
    endfunction

    function void restart();
      open_line();
      flags_word = 32'd0;
      seen       = 4'd0;
      err        = 1'b0;
    endfunction

    function string key_text(key_t k);
      case (k)
        K_FORMAT: return "format";
        K_ID:     return "id";
        K_NAME:   return "name";
        K_EXEC:   return "exec";
        K_FLAGS:  return "flags";
        default:  return "";
      endcase
    endfunction

    function int capacity(key_t k);
      case (k)
        K_ID:    return ID_CAP;
        K_NAME:  return NAME_CAP;
        default: return EXEC_CAP;
      endcase
    endfunction

    function field_t field_for(key_t k);
      case (k)
        K_ID:    return FLD_ID;
        K_NAME:  return FLD_NAME;
        default: return FLD_EXEC;
      endcase
    endfunction

    function void emit(ev_kind_t kind, logic [1:0] fld, logic [6:0] pos, logic [7:0] ch,
                       logic ok, logic [31:0] fl, logic fmt);
      out_item_t e;
      if (step_events.size() >= MAX_EVENTS) return;
      e.event_kind     = kind;
      e.field_code     = fld;
      e.char_position  = pos;
      e.char_value     = ch;
      e.manifest_ok    = ok;
      e.flags_value    = fl;
      e.format_version = fmt;
      e.last_of_run    = 1'b0;
      step_events.push_back(e);
    endfunction

    function void end_line();
      if (!err) begin
        if (phase == PH_KEY) begin
          err = 1'b1;
        end else if (phase == PH_VALUE) begin
          if (vlen == 8'd0) begin
            err = 1'b1;
          end else if (akey == K_FORMAT) begin
            if (acc != FORMAT_ONE) err = 1'b1;
            else seen[0] = 1'b1;
          end else if (akey == K_FLAGS) begin
            flags_word = acc;
          end else begin
            emit(EV_END, field_for(akey), vlen[6:0], 8'h00, 1'b0, 32'd0, 1'b0);
            seen[int'(akey)] = 1'b1;
          end
        end
      end
      open_line();
    endfunction

    function void key_char(logic [7:0] b);
      string s;
      for (int c = 0; c < NUM_KEYS; c++) begin
        s = key_text(key_t'(c));
        if (cand[c] && (kpos >= s.len() || s[kpos] != b)) cand[c] = 1'b0;
      end
      if (kpos < 3'd7) kpos++;
    endfunction

    function void key_end();
      string s;
      akey = K_NONE;
      for (int c = 0; c < NUM_KEYS; c++) begin
        s = key_text(key_t'(c));
        if (cand[c] && s.len() == kpos) akey = key_t'(c);
      end
      phase = (akey == K_NONE) ? PH_SKIP : PH_VALUE;
    endfunction

    function void value_char(logic [7:0] b);
      logic [31:0] d;
      if (akey == K_FORMAT || akey == K_FLAGS) begin
        if (b < CH_ZERO || b > CH_NINE) begin
          err = 1'b1;
          return;
        end
        d = 32'(b) - 32'(CH_ZERO);
        if (acc > (32'hFFFF_FFFF - d) / 32'd10) begin
          err = 1'b1;
          return;
        end
        acc = acc * 32'd10 + d;
        if (vlen != 8'hFF) vlen++;
        return;
      end
      if (b < CH_PRINT_LO || b > CH_PRINT_HI) begin
        err = 1'b1;
        return;
      end
      if (int'(vlen) + 1 >= capacity(akey)) begin
        err = 1'b1;
        return;
      end
      if (akey == K_EXEC && vlen == 8'd0 && b != CH_SLASH) begin
        err = 1'b1;
        return;
      end
      emit(EV_BYTE, field_for(akey), vlen[6:0], b, 1'b0, 32'd0, 1'b0);
      vlen++;
    endfunction

    function void note_text(in_item_t it);
      logic [7:0] b;
      out_item_t  tail;
      b = it.data_byte;
      step_events.delete();
      if (!err) begin
        if (b == CH_LF || b == CH_CR || b == CH_NUL) begin
          end_line();
        end else begin
          case (phase)
            PH_START: begin
              if (b == CH_HASH) phase = PH_SKIP;
              else if (b == CH_EQ) err = 1'b1;
              else begin
                phase = PH_KEY;
                key_char(b);
              end
            end
            PH_KEY: begin
              if (b == CH_EQ) key_end();
              else key_char(b);
            end
            PH_VALUE: value_char(b);
            default: ;
          endcase
        end
      end
      if (it.last_byte) begin
        end_line();
        emit(EV_VERDICT, FLD_ID, 7'd0, 8'h00, !err && seen == 4'hF,
             err ? 32'd0 : flags_word, !err && seen[0]);
        verdicts++;
        if (!err && seen == 4'hF) good_verdicts++;
        restart();
      end
      if (step_events.size() > 0) begin
        tail = step_events.pop_back();
        tail.last_of_run = 1'b1;
        step_events.push_back(tail);
      end
      foreach (step_events[i]) begin
        if (step_events[i].event_kind != EV_VERDICT) string_events++;
        expected_events.push_back(step_events[i]);
      end
    endfunction

    function void mismatch(string what, logic [31:0] want, logic [31:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (expected_events.size() == 0) begin
        failures++;
        $display("%0t: event beat with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind)
        mismatch("event_kind", want.event_kind, got.event_kind);
      if (got.field_code !== want.field_code)
        mismatch("field_code", want.field_code, got.field_code);
      if (got.char_position !== want.char_position)
        mismatch("char_position", want.char_position, got.char_position);
      if (got.char_value !== want.char_value)
        mismatch("char_value", want.char_value, got.char_value);
      if (got.manifest_ok !== want.manifest_ok)
        mismatch("manifest_ok", want.manifest_ok, got.manifest_ok);
      if (got.flags_value !== want.flags_value)
        mismatch("flags_value", want.flags_value, got.flags_value);
      if (got.format_version !== want.format_version)
        mismatch("format_version", want.format_version, got.format_version);
      if (got.last_of_run !== want.last_of_run)
        mismatch("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlp_in_if  text_bus ();
  mlp_out_if event_bus ();

  manifest_line_parser_core #(
    .ID_CAPACITY   (ID_CAP),
    .NAME_CAPACITY (NAME_CAP),
    .EXEC_CAPACITY (EXEC_CAP)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_bus),
    .events (event_bus)
  );

  manifest_scoreboard board;
  in_item_t           text_plan[$];
  bit                 tail_calm = 1'b0;
  int                 bytes_taken = 0;
  int                 idle_run = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // text plan: manifests built line by line, the final byte of each one marked
  // ---------------------------------------------------------------------------

  function automatic void put_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = 1'b0;
    text_plan.push_back(it);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // every line end flavour, crlf giving an extra empty line
  function automatic void put_eol();
    case ($urandom_range(0, 4))
      0, 1: put_byte(CH_LF);
      2: put_byte(CH_CR);
      3: put_byte(CH_NUL);
      default: begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
    endcase
  endfunction

  function automatic void mark_last();
    in_item_t it;
    it = text_plan.pop_back();
    it.last_byte = 1'b1;
    text_plan.push_back(it);
  endfunction

  function automatic void put_printable(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(32, 126)));
  endfunction

  // anything but a line end, for comments and ignored values
  function automatic void put_junk(int n);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(14, 255)));
  endfunction

  // mostly short strings, now and then the longest one that fits
  function automatic int pick_len(int cap);
    case ($urandom_range(0, 19))
      0: return cap - 1;
      1: return $urandom_range(1, cap - 1);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [63:0] pick_flags();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF;
      2: return 64'($urandom);
      default: return 64'($urandom_range(0, 999));
    endcase
  endfunction

  function automatic void put_string_line(string key, int n, bit slash);
    put_text(key);
    put_byte(CH_EQ);
    if (slash && n > 0) begin
      put_byte(CH_SLASH);
      put_printable(n - 1);
    end else begin
      put_printable(n);
    end
  endfunction

  // decimal value, sometimes with a harmless leading zero
  function automatic void put_number_line(string key, logic [63:0] v);
    put_text(key);
    put_byte(CH_EQ);
    if ($urandom_range(0, 5) == 0) put_byte(CH_ZERO);
    put_text($sformatf("%0d", v));
  endfunction

  // near misses of the known keys, a key past the position counter among them
  function automatic string other_key();
    case ($urandom_range(0, 7))
      0: return "fo";
      1: return "formats";
      2: return "ids";
      3: return "nam";
      4: return "executable";
      5: return "flag";
      6: return "x";
      default: return "flagsflags";
    endcase
  endfunction

  function automatic string known_key();
    case ($urandom_range(0, 4))
      0: return "format";
      1: return "id";
      2: return "name";
      3: return "exec";
      default: return "flags";
    endcase
  endfunction

  // one line that makes the whole manifest fail
  function automatic void put_fault();
    case ($urandom_range(0, 9))
      0: put_text(known_key());                      // key with no '='
      1: begin                                       // empty key
        put_byte(CH_EQ);
        put_printable($urandom_range(0, 4));
      end
      2: begin                                       // empty value
        put_text(known_key());
        put_byte(CH_EQ);
      end
      3: put_number_line("format", $urandom_range(0, 1) ? 64'd0
                                   : 64'($urandom_range(2, 1000)));
      4: begin                                       // non-digit in a number
        put_text($urandom_range(0, 1) ? "format" : "flags");
        put_byte(CH_EQ);
        put_text($sformatf("%0d", $urandom_range(0, 99)));
        put_byte(8'($urandom_range(8'h3A, 8'hFF)));
      end
      5: put_number_line("flags", 64'h1_0000_0000 + 64'($urandom));
      6: begin                                       // control or high byte
        put_text($urandom_range(0, 1) ? "id" : "name");
        put_byte(CH_EQ);
        put_printable($urandom_range(0, 3));
        put_byte($urandom_range(0, 1) ? 8'($urandom_range(1, 9))
                                      : 8'($urandom_range(127, 255)));
      end
      7: begin                                       // one byte over capacity
        if ($urandom_range(0, 1)) put_string_line("id", ID_CAP, 1'b0);
        else put_string_line("name", NAME_CAP, 1'b0);
      end
      8: begin                                       // exec not starting with '/'
        put_text("exec");
        put_byte(CH_EQ);
        put_byte(8'($urandom_range(8'h30, 8'h7E)));
        put_printable($urandom_range(0, 4));
      end
      default: put_text("formatting");               // long key, no '='
    endcase
  endfunction

  function automatic void put_line(line_t k);
    case (k)
      LN_FORMAT:  put_number_line("format", 64'd1);
      LN_ID:      put_string_line("id", pick_len(ID_CAP), 1'b0);
      LN_NAME:    put_string_line("name", pick_len(NAME_CAP), 1'b0);
      LN_EXEC:    put_string_line("exec", pick_len(EXEC_CAP), 1'b1);
      LN_FLAGS:   put_number_line("flags", pick_flags());
      LN_COMMENT: begin
        put_byte(CH_HASH);
        put_junk($urandom_range(0, 8));
      end
      LN_OTHER: begin
        put_text(other_key());
        put_byte(CH_EQ);
        put_junk($urandom_range(0, 6));
      end
      LN_FAULT:   put_fault();
      default: ;
    endcase
  endfunction

  function automatic void plan_random_manifest();
    line_t lines[$];
    line_t swap;
    int    j;
    int    style;
    style = $urandom_range(0, 9);
    // raw noise, cut off wherever it happens to end
    if (style == 0) begin
      for (int i = $urandom_range(1, 24); i > 0; i--) put_byte(8'($urandom));
      mark_last();
      return;
    end
    lines = '{LN_FORMAT, LN_ID, LN_NAME, LN_EXEC};
    if ($urandom_range(0, 9) == 0) lines.delete($urandom_range(0, 3));
    if ($urandom_range(0, 1)) lines.push_back(LN_FLAGS);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: lines.push_back(LN_COMMENT);
        1: lines.push_back(LN_BLANK);
        2: lines.push_back(LN_OTHER);
        3: lines.push_back(LN_ID);          // duplicate overwrites
        4: lines.push_back(LN_EXEC);
        default: lines.push_back(LN_FLAGS);
      endcase
    end
    if (style <= 3) lines.push_back(LN_FAULT);
    for (int i = lines.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = lines[i];
      lines[i] = lines[j];
      lines[j] = swap;
    end
    foreach (lines[i]) begin
      put_line(lines[i]);
      // the final line is often left open, closed only by the last flag
      if (i != lines.size() - 1 || lines[i] == LN_BLANK || $urandom_range(0, 1))
        put_eol();
    end
    mark_last();
  endfunction

  // short directed opening: printable bounds, a final byte inside a string
  // value (byte, end and verdict from one beat), an empty key, a lone high
  // byte left as an unfinished key, and an empty manifest
  function automatic void plan_directed();
    put_text("format=1");
    put_byte(CH_LF);
    put_string_line("id", 0, 1'b0);
    put_byte(CH_PRINT_LO);
    put_byte(CH_CR);
    put_text("name=");
    put_byte(CH_PRINT_HI);
    put_byte(CH_NUL);
    put_text("exec=");
    put_byte(CH_SLASH);
    mark_last();
    put_byte(CH_EQ);
    mark_last();
    put_byte(8'hFF);
    mark_last();
    put_byte(CH_NUL);
    mark_last();
  endfunction

  // ---------------------------------------------------------------------------
  // driving and monitoring
  // ---------------------------------------------------------------------------

  // hold the beat until the parser takes it
  task automatic send_byte(input in_item_t it);
    text_bus.valid <= 1'b1;
    text_bus.data  <= it;
    do @(posedge clk); while (text_bus.ready !== 1'b1);
  endtask

  // event consumer: random stall bursts between ready runs
  initial begin
    event_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!tail_calm && $urandom_range(0, 3) == 0) begin
        event_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      event_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // beats are sampled at the edge that accepts them, before any update
  always @(posedge clk) begin
    if (!rst) begin
      if (text_bus.valid && text_bus.ready) begin
        board.note_text(text_bus.data);
        bytes_taken++;
      end
      if (event_bus.valid && event_bus.ready) board.check_event(event_bus.data);
      if ((text_bus.valid && text_bus.ready) || (event_bus.valid && event_bus.ready))
        idle_run = 0;
      else
        idle_run++;
      // watchdog: no beat on either side for far too long
      if (idle_run >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d event beats still expected",
                 $time, idle_run, board.expected_events.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int directed_count;
    bit gaps_on;
    board = new();
    text_bus.valid <= 1'b0;
    text_bus.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    plan_directed();
    directed_count = text_plan.size();
    while (text_plan.size() < directed_count + RANDOM_BYTES) plan_random_manifest();

    @(posedge clk);
    gaps_on = 1'b0;
    foreach (text_plan[i]) begin
      // sender gaps come and go in stretches, none at all near the end
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (text_plan.size() - i == QUIET_TAIL) tail_calm <= 1'b1;
      if (text_plan.size() - i > QUIET_TAIL && gaps_on && $urandom_range(0, 5) == 0) begin
        text_bus.valid <= 1'b0;
        text_bus.data  <= in_item_t'(9'($urandom));
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      send_byte(text_plan[i]);
    end
    text_bus.valid <= 1'b0;

    // drain the event queue, the watchdog covers a beat that never comes
    while (board.expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d text bytes and %0d string field events", bytes_taken,
             board.string_events);
    $display("%0d manifests closed, %0d of them complete and error free",
             board.verdicts, board.good_verdicts);
    if (board.failures == 0 && board.expected_events.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
